>>> hdl/vptm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the versioned peer table merge block.
// Used by vptm_cell and versioned_peer_table_merge_core; depends on nothing.

package vptm_pkg;

    // Fixed field widths of the peer record and of the result item.
    localparam int ID_W      = 256;
    localparam int WORD_W    = 64;
    localparam int VER_W     = 32;
    localparam int SLOT_W    = 8;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 3'd4;

    localparam logic [SLOT_W-1:0] ENTRY_LIMIT_RESET = 8'd16;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SELF,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    // Search token handed from cell to cell along the chain.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] idx;
        logic [VER_W-1:0]  ver;
        logic              empty;
    } token_t;

    // Write command broadcast to every cell; the addressed cell takes it.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic [VER_W-1:0]  ver;
        logic [ID_W-1:0]   id;
    } wr_cmd_t;

endpackage

>>> hdl/versioned_peer_table_merge_core.sv
`timescale 1ns / 1ps
// The search token walks the chain of entry cells one cell a cycle; a new item is
// taken only when the last one is through, and busy is low again in the done cycle.
// Reset clears all entries, the own version, the entry count and the highest version.
// Results are shown for one cycle on done; the receiver cannot stall them.
// Depends on vptm_pkg and vptm_cell.

module versioned_peer_table_merge_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int INFO_BITS   = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cfg_we,
    input  logic [vptm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vptm_pkg::WORD_W-1:0]     cfg_data,
    input  logic [vptm_pkg::WORD_W-1:0]     id_word0,
    input  logic [vptm_pkg::WORD_W-1:0]     id_word1,
    input  logic [vptm_pkg::WORD_W-1:0]     id_word2,
    input  logic [vptm_pkg::WORD_W-1:0]     id_word3,
    input  logic [vptm_pkg::VER_W-1:0]      version,
    input  logic [vptm_pkg::WORD_W-1:0]     node_info,
    output logic                            done,
    output logic                            status,
    output logic                            applied,
    output logic                            new_node,
    output logic                            hit_self,
    output logic [vptm_pkg::SLOT_W-1:0]     slot_index,
    output logic [vptm_pkg::VER_W-1:0]      newest_version
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    vptm_pkg::state_t state_reg;
    vptm_pkg::state_t state_next;

    // Configuration registers.
    logic [vptm_pkg::ID_W-1:0]   own_id_reg;
    logic [vptm_pkg::SLOT_W-1:0] limit_reg;

    // Item registers.
    logic [vptm_pkg::ID_W-1:0]  item_id_reg;
    logic [vptm_pkg::VER_W-1:0] item_ver_reg;
    logic [INFO_BITS-1:0]       item_info_reg;
    logic                       self_reg;
    vptm_pkg::token_t           found_reg;

    // Block state outside the cells.
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [vptm_pkg::VER_W-1:0] own_ver_reg;
    logic [vptm_pkg::VER_W-1:0] own_ver_next;
    logic [INFO_BITS-1:0]       own_info_reg;
    logic [INFO_BITS-1:0]       own_info_next;
    logic [vptm_pkg::VER_W-1:0] highest_reg;
    logic [vptm_pkg::VER_W-1:0] highest_next;

    // Result registers.
    logic                        done_reg;
    logic                        done_next;
    logic                        status_reg;
    logic                        status_next;
    logic                        applied_reg;
    logic                        applied_next;
    logic                        new_node_reg;
    logic                        new_node_next;
    logic                        hit_self_reg;
    logic                        hit_self_next;
    logic [vptm_pkg::SLOT_W-1:0] slot_reg;
    logic [vptm_pkg::SLOT_W-1:0] slot_next;

    // Chain signals.
    vptm_pkg::token_t  chain_tok [TABLE_DEPTH+1];
    vptm_pkg::wr_cmd_t wr_cmd;
    vptm_pkg::token_t  tok_end;

    // Decision terms.
    logic                        accept;
    logic                        full;
    logic                        slot_empty;
    logic [vptm_pkg::VER_W-1:0]  slot_ver;
    logic [vptm_pkg::SLOT_W-1:0] use_idx;
    logic                        apply;
    logic                        append;

    assign accept  = start && (state_reg == vptm_pkg::ST_IDLE);
    assign tok_end = chain_tok[TABLE_DEPTH];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
            limit_reg  <= vptm_pkg::ENTRY_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vptm_pkg::CFG_OWN_ID0:     own_id_reg[63:0]    <= cfg_data;
                vptm_pkg::CFG_OWN_ID1:     own_id_reg[127:64]  <= cfg_data;
                vptm_pkg::CFG_OWN_ID2:     own_id_reg[191:128] <= cfg_data;
                vptm_pkg::CFG_OWN_ID3:     own_id_reg[255:192] <= cfg_data;
                vptm_pkg::CFG_ENTRY_LIMIT: limit_reg <= cfg_data[vptm_pkg::SLOT_W-1:0];
                default:                   limit_reg <= limit_reg;
            endcase
        end
    end

    // Item capture on acceptance; the self check is taken in the following state, and the
    // search token is held as it leaves the last cell, since it stays there one cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_id_reg   <= {id_word3, id_word2, id_word1, id_word0};
            item_ver_reg  <= version;
            item_info_reg <= node_info[INFO_BITS-1:0];
        end
        if (state_reg == vptm_pkg::ST_SELF)
        begin
            self_reg <= (own_id_reg == item_id_reg);
        end
        if ((state_reg == vptm_pkg::ST_SCAN) && tok_end.valid)
        begin
            found_reg <= tok_end;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vptm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = vptm_pkg::ST_SELF;
                end
            end
            vptm_pkg::ST_SELF:
            begin
                state_next = vptm_pkg::ST_SCAN;
            end
            vptm_pkg::ST_SCAN:
            begin
                if (tok_end.valid)
                begin
                    state_next = vptm_pkg::ST_DECIDE;
                end
            end
            vptm_pkg::ST_DECIDE:
            begin
                state_next = vptm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vptm_pkg::ST_IDLE;
            end
        endcase
    end

    // Token launched into the first cell while the self check is taken.
    always_comb
    begin
        chain_tok[0]       = '0;
        chain_tok[0].valid = (state_reg == vptm_pkg::ST_SELF);
    end

    // Slot choice: own identity first, then the first matching entry, then append.
    always_comb
    begin
        full       = 1'b0;
        append     = 1'b0;
        slot_empty = 1'b1;
        slot_ver   = '0;
        use_idx    = '0;
        if (self_reg)
        begin
            slot_empty = (own_id_reg == '0);
            slot_ver   = own_ver_reg;
        end
        else if (found_reg.hit)
        begin
            slot_empty = found_reg.empty;
            slot_ver   = found_reg.ver;
            use_idx    = found_reg.idx;
        end
        else if ((vptm_pkg::SLOT_W'(count_reg) < limit_reg) &&
                 (count_reg < CNT_W'(TABLE_DEPTH)))
        begin
            // Entries at and above the fill count always hold a zero identifier.
            append  = 1'b1;
            use_idx = vptm_pkg::SLOT_W'(count_reg);
        end
        else
        begin
            full = 1'b1;
        end
        apply = !full && (slot_empty || !(slot_ver > item_ver_reg));
    end

    // Outputs of the sequencer: writes, state updates and the result item.
    always_comb
    begin
        wr_cmd        = '0;
        wr_cmd.idx    = use_idx;
        wr_cmd.ver    = item_ver_reg;
        wr_cmd.id     = item_id_reg;
        count_next    = count_reg;
        own_ver_next  = own_ver_reg;
        own_info_next = own_info_reg;
        highest_next  = highest_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        applied_next  = applied_reg;
        new_node_next = new_node_reg;
        hit_self_next = hit_self_reg;
        slot_next     = slot_reg;
        if (state_reg == vptm_pkg::ST_DECIDE)
        begin
            done_next     = 1'b1;
            status_next   = full;
            applied_next  = apply;
            new_node_next = apply && slot_empty;
            hit_self_next = self_reg;
            slot_next     = use_idx;
            if (apply)
            begin
                if (self_reg)
                begin
                    own_ver_next  = item_ver_reg;
                    own_info_next = item_info_reg;
                end
                else
                begin
                    wr_cmd.en = 1'b1;
                end
                if (item_ver_reg > highest_reg)
                begin
                    highest_next = item_ver_reg;
                end
            end
            if (append)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Control and table state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vptm_pkg::ST_IDLE;
            count_reg    <= '0;
            own_ver_reg  <= '0;
            own_info_reg <= '0;
            highest_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            own_ver_reg  <= own_ver_next;
            own_info_reg <= own_info_next;
            highest_reg  <= highest_next;
            done_reg     <= done_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        applied_reg  <= applied_next;
        new_node_reg <= new_node_next;
        hit_self_reg <= hit_self_next;
        slot_reg     <= slot_next;
    end

    // Chain of entry cells.
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        vptm_cell #(
            .CELL_IDX  (g),
            .INFO_BITS (INFO_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .count    (vptm_pkg::SLOT_W'(count_reg)),
            .probe_id (item_id_reg),
            .tok_in   (chain_tok[g]),
            .tok_out  (chain_tok[g+1]),
            .wr       (wr_cmd),
            .wr_info  (item_info_reg)
        );
    end

    assign busy           = (state_reg != vptm_pkg::ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign applied        = applied_reg;
    assign new_node       = new_node_reg;
    assign hit_self       = hit_self_reg;
    assign slot_index     = slot_reg;
    assign newest_version = highest_reg;

    // A result item only follows a decision cycle.
    a_done_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == vptm_pkg::ST_DECIDE))
        else $error("done without a decision cycle");

    // A dropped item changes nothing and claims no slot.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (!applied && !hit_self && !new_node && slot_index == '0))
        else $error("table full result carries slot data");

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // The highest applied version never falls.
    a_highest_mono: assert property (@(posedge clk) disable iff (!rst_n)
        highest_reg >= $past(highest_reg))
        else $error("highest version decreased");

    // Entries only grow by one, and only in a decision cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ($past(state_reg == vptm_pkg::ST_DECIDE) && count_reg == $past(count_reg) + 1'b1))
        else $error("entry count changed outside an append");

endmodule

>>> hdl/vptm_cell.sv
`timescale 1ns / 1ps
// One peer table entry with its identifier comparator and a token stage.
// Depends on vptm_pkg for the token and write command types.

module vptm_cell #(
    parameter int CELL_IDX  = 0,
    parameter int INFO_BITS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [vptm_pkg::SLOT_W-1:0] count,
    input  logic [vptm_pkg::ID_W-1:0]  probe_id,
    input  vptm_pkg::token_t           tok_in,
    output vptm_pkg::token_t           tok_out,
    input  vptm_pkg::wr_cmd_t          wr,
    input  logic [INFO_BITS-1:0]       wr_info
);

    logic [vptm_pkg::ID_W-1:0]  id_reg;
    logic [vptm_pkg::VER_W-1:0] ver_reg;
    logic [INFO_BITS-1:0]       info_reg;
    vptm_pkg::token_t           tok_reg;
    vptm_pkg::token_t           tok_next;
    logic                       in_range;
    logic                       match;
    logic                       wr_sel;

    // The entry takes part in the search only below the fill count.
    assign in_range = vptm_pkg::SLOT_W'(CELL_IDX) < count;
    assign match    = in_range && (id_reg == probe_id);
    assign wr_sel   = wr.en && (wr.idx == vptm_pkg::SLOT_W'(CELL_IDX));

    // The first matching entry claims the token; later cells pass it on.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.hit && match)
        begin
            tok_next.hit   = 1'b1;
            tok_next.idx   = vptm_pkg::SLOT_W'(CELL_IDX);
            tok_next.ver   = ver_reg;
            tok_next.empty = (id_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Entry storage, cleared on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg   <= '0;
            ver_reg  <= '0;
            info_reg <= '0;
        end
        else if (wr_sel)
        begin
            id_reg   <= wr.id;
            ver_reg  <= wr.ver;
            info_reg <= wr_info;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for versioned_peer_table_merge_core: directed and random peer
// records are checked against an in-bench model of the peer table merge.
// Depends on vptm_pkg and the RTL of the block; reads no files.

module tb;

    import vptm_pkg::*;

    localparam int DEPTH          = 16;
    localparam int LATENCY        = DEPTH + 3;
    localparam int TAIL_CYCLES    = LATENCY + 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_SIZE      = 24;
    localparam int PHASE_ITEMS    = 190;
    localparam int REPORT_LIMIT   = 10;

    // Index past the last register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [VER_W-1:0]  ver;
        logic [WORD_W-1:0] info;
    } peer_rec_t;

    typedef struct packed {
        logic              status;
        logic              applied;
        logic              new_node;
        logic              hit_self;
        logic [SLOT_W-1:0] slot;
        logic [VER_W-1:0]  newest;
    } merge_res_t;

    // Model of the peer table and queue of the results it predicts.
    // The info words are never visible at the outputs, so they are not held.
    class peer_merge_board;
        logic [ID_W-1:0]  own_id;
        logic [7:0]       entry_limit;
        logic [ID_W-1:0]  entry_ids[DEPTH];
        logic [VER_W-1:0] entry_vers[DEPTH];
        int unsigned      entry_count;
        logic [VER_W-1:0] own_ver;
        logic [VER_W-1:0] top_ver;
        merge_res_t       pending_results[$];
        int unsigned      errors;

        function new();
            own_id      = '0;
            entry_limit = ENTRY_LIMIT_RESET;
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_ids[i]  = '0;
                entry_vers[i] = '0;
            end
            entry_count = 0;
            own_ver     = '0;
            top_ver     = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                CFG_OWN_ID0:     own_id[0   +: WORD_W] = data;
                CFG_OWN_ID1:     own_id[64  +: WORD_W] = data;
                CFG_OWN_ID2:     own_id[128 +: WORD_W] = data;
                CFG_OWN_ID3:     own_id[192 +: WORD_W] = data;
                CFG_ENTRY_LIMIT: entry_limit = data[7:0];
                default:         ;
            endcase
        endfunction

        // Merges one record into the table and returns the result it causes.
        function merge_res_t merge_record(peer_rec_t r);
            merge_res_t       res;
            int unsigned      slot;
            bit               found;
            bit               self_hit;
            bit               vacant;
            logic [VER_W-1:0] held;
            res      = '0;
            slot     = 0;
            self_hit = (r.id == own_id);
            found    = self_hit;
            for (int i = 0; i < entry_count && i < DEPTH && !found; i++)
            begin
                if (entry_ids[i] == r.id)
                begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            // A new identifier takes the next free slot unless the table is full.
            if (!found)
            begin
                if (entry_count >= entry_limit || entry_count >= DEPTH)
                begin
                    res.status = 1'b1;
                    res.newest = top_ver;
                    return res;
                end
                slot = entry_count;
                entry_count++;
            end
            vacant       = self_hit ? (own_id == '0) : (entry_ids[slot] == '0);
            held         = self_hit ? own_ver : entry_vers[slot];
            res.hit_self = self_hit;
            res.slot     = self_hit ? '0 : SLOT_W'(slot);
            // An occupied slot with a strictly newer version keeps its contents.
            if (!vacant && held > r.ver)
            begin
                res.newest = top_ver;
                return res;
            end
            if (self_hit)
                own_ver = r.ver;
            else
            begin
                entry_ids[slot]  = r.id;
                entry_vers[slot] = r.ver;
            end
            if (r.ver > top_ver)
                top_ver = r.ver;
            res.applied  = 1'b1;
            res.new_node = vacant;
            res.newest   = top_ver;
            return res;
        endfunction

        function void note_item(peer_rec_t r);
            pending_results.push_back(merge_record(r));
        endfunction

        function void flag_field(string name, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, name,
                         want, got);
        endfunction

        function void check_result(merge_res_t got);
            merge_res_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result with no item waiting: %0h", $realtime, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                flag_field("status", want.status, got.status);
            if (got.applied !== want.applied)
                flag_field("applied", want.applied, got.applied);
            if (got.new_node !== want.new_node)
                flag_field("new_node", want.new_node, got.new_node);
            if (got.hit_self !== want.hit_self)
                flag_field("hit_self", want.hit_self, got.hit_self);
            if (got.slot !== want.slot)
                flag_field("slot_index", want.slot, got.slot);
            if (got.newest !== want.newest)
                flag_field("newest_version", want.newest, got.newest);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    logic [WORD_W-1:0]    id_word0;
    logic [WORD_W-1:0]    id_word1;
    logic [WORD_W-1:0]    id_word2;
    logic [WORD_W-1:0]    id_word3;
    logic [VER_W-1:0]     version;
    logic [WORD_W-1:0]    node_info;
    logic                 done;
    logic                 status;
    logic                 applied;
    logic                 new_node;
    logic                 hit_self;
    logic [SLOT_W-1:0]    slot_index;
    logic [VER_W-1:0]     newest_version;

    peer_merge_board board;
    logic [ID_W-1:0] id_pool[POOL_SIZE];
    logic [ID_W-1:0] cur_own;
    int              sent;
    int              idle_cycles;
    bit              steady;

    versioned_peer_table_merge_core #(
        .TABLE_DEPTH (DEPTH),
        .INFO_BITS   (64)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .id_word0       (id_word0),
        .id_word1       (id_word1),
        .id_word2       (id_word2),
        .id_word3       (id_word3),
        .version        (version),
        .node_info      (node_info),
        .done           (done),
        .status         (status),
        .applied        (applied),
        .new_node       (new_node),
        .hit_self       (hit_self),
        .slot_index     (slot_index),
        .newest_version (newest_version)
    );

    // Clock: 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sample register writes, accepted items and results at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                board.note_item({id_word3, id_word2, id_word1, id_word0, version, node_info});
            if (done)
                board.check_result({status, applied, new_node, hit_self, slot_index,
                                    newest_version});
        end
    end

    // Watchdog: ends the run when no item has been accepted and no result has arrived for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [ID_W-1:0] rand_id();
        logic [ID_W-1:0] v;
        for (int k = 0; k < ID_W / 32; k++)
            v[32*k +: 32] = $urandom;
        return v;
    endfunction

    function automatic peer_rec_t make_rec(logic [ID_W-1:0] id, logic [VER_W-1:0] ver);
        peer_rec_t r;
        r.id   = id;
        r.ver  = ver;
        r.info = {$urandom, $urandom};
        return r;
    endfunction

    // Mostly known identifiers, so that lookups hit; versions widen as the run goes on.
    function automatic peer_rec_t random_rec(bit allow_max);
        peer_rec_t r;
        int        pick;
        int        w;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            r.id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 80)
            r.id = cur_own;
        else if (pick < 88)
            r.id = '0;
        else
            r.id = rand_id();
        w = 4 + (sent * 28) / 900;
        if (w > 32)
            w = 32;
        pick = $urandom_range(0, 31);
        if (allow_max && pick == 0)
            r.ver = '1;
        else if (pick < 5)
            r.ver = $urandom_range(0, 15);
        else
            r.ver = $urandom & (32'hFFFF_FFFF >> (32 - w));
        r.info = {$urandom, $urandom};
        return r;
    endfunction

    // Presents one item, waits for it to be taken, then idles for a random gap that
    // is counted either from acceptance or from the result strobe.
    task automatic send_item(peer_rec_t r);
        int gap;
        bit after_done;
        {id_word3, id_word2, id_word1, id_word0} <= r.id;
        version   <= r.ver;
        node_info <= r.info;
        start     <= 1'b1;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        sent++;
        gap        = steady ? 0 : $urandom_range(0, 5);
        after_done = steady ? 1'b0 : 1'($urandom_range(0, 1));
        if (gap != 0 || after_done)
        begin
            start <= 1'b0;
            if (after_done)
            begin
                do
                    @(negedge clk);
                while (!done);
                @(posedge clk);
            end
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_own(logic [ID_W-1:0] id);
        write_cfg(CFG_OWN_ID0, id[0   +: WORD_W]);
        write_cfg(CFG_OWN_ID1, id[64  +: WORD_W]);
        write_cfg(CFG_OWN_ID2, id[128 +: WORD_W]);
        write_cfg(CFG_OWN_ID3, id[192 +: WORD_W]);
    endtask

    // The upper data bits are random: only the low byte may take effect.
    task automatic write_limit(logic [7:0] lim);
        logic [WORD_W-1:0] data;
        data      = {$urandom, $urandom};
        data[7:0] = lim;
        write_cfg(CFG_ENTRY_LIMIT, data);
    endtask

    initial
    begin
        board       = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        id_word0    = '0;
        id_word1    = '0;
        id_word2    = '0;
        id_word3    = '0;
        version     = '0;
        node_info   = '0;
        sent        = 0;
        idle_cycles = 0;
        steady      = 1'b0;
        cur_own     = '0;

        // Identifier pool; every odd entry from index 3 on differs from its predecessor in one bit.
        id_pool[0] = '1;
        for (int k = 1; k < POOL_SIZE; k++)
            id_pool[k] = (k % 2 == 1 && k > 2) ?
                         id_pool[k-1] ^ (256'd1 << $urandom_range(0, ID_W - 1)) : rand_id();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Own identifier is zero after reset, so a zero identifier hits the own slot.
        send_item(make_rec('0, 32'd5));
        send_item(make_rec('1, 32'd16));
        send_item(make_rec('1, 32'd3));
        send_item(make_rec('1, 32'd16));
        send_item(make_rec(id_pool[2], 32'd0));
        send_item(make_rec(id_pool[3], 32'd7));

        // Own identifier set, limit equal to the entry count: new identifiers are dropped.
        settle();
        cur_own = id_pool[4];
        set_own(cur_own);
        write_limit(8'd3);
        send_item(make_rec(id_pool[4], 32'd9));
        send_item(make_rec(id_pool[4], 32'd1));
        send_item(make_rec('0, 32'd2));
        send_item(make_rec(id_pool[5], 32'hFFFF_FFFF));
        send_item(make_rec(id_pool[2], 32'd4));

        // A stored zero identifier counts as empty and takes even an older version.
        settle();
        write_limit(8'hFF);
        write_cfg(CFG_SPARE, {$urandom, $urandom});
        send_item(make_rec('0, 32'd1));
        send_item(make_rec('0, 32'd0));
        send_item(make_rec(id_pool[5], 32'd0));

        // Limit lowered below the entry count: updates go on, appends stop.
        settle();
        write_limit(8'd2);
        send_item(make_rec('1, 32'd100));
        send_item(make_rec(id_pool[6], 32'd1));
        send_item(make_rec(id_pool[3], 32'd6));

        settle();
        write_limit(8'd0);
        send_item(make_rec(id_pool[4], 32'd9));
        send_item(make_rec(id_pool[7], 32'd1));

        // Random phases, each under its own setting of the registers.
        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0: write_limit(ENTRY_LIMIT_RESET);
                1:
                begin
                    cur_own = id_pool[$urandom_range(8, POOL_SIZE - 1)];
                    set_own(cur_own);
                    write_limit(8'($urandom_range(0, 20)));
                end
                2: write_limit(8'hFF);
                3: write_limit(8'h00);
                4:
                begin
                    cur_own = '0;
                    set_own(cur_own);
                    write_limit(8'(DEPTH));
                end
                default:
                begin
                    cur_own = rand_id();
                    set_own(cur_own);
                    write_limit(8'($urandom_range(0, 255)));
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                steady = ((k / 32) % 3 == 1);
                send_item(random_rec(p == 5));
            end
        end

        settle();
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
